@@ hdl/stbs_pkg.sv @@
// Shared types and constants for the sorted table binary search unit.
// Depends on nothing; every other file refers to it by scoped names.

package stbs_pkg;

  // Input opcodes
  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_LOAD  = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  // Result status codes
  localparam logic [2:0] ST_LOADED   = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_CLEARED  = 3'd2;
  localparam logic [2:0] ST_FOUND    = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;

  // Depth of the command queue between front and back
  localparam int CMD_Q_DEPTH = 2;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] position;
  } out_item_t;

  typedef enum logic [1:0] {
    CMD_CLEAR,
    CMD_LOAD,
    CMD_QUERY
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic signed [31:0] value;
  } cmd_t;

  typedef enum logic [2:0] {
    ENG_IDLE,
    ENG_INS_CMP,
    ENG_INS_WR,
    ENG_SRCH_RD,
    ENG_SRCH_CMP,
    ENG_RESP
  } eng_state_t;

endpackage

@@ hdl/sorted_table_binary_search_unit.sv @@
// Top level of the sorted table binary search unit: front stage, command queue, engine.
// Depends on stbs_pkg, stbs_front, stbs_cmd_fifo and stbs_engine.
//
//   Channel | Ports                         | Carries
//   --------+-------------------------------+------------------------------------
//   in      | in_valid, in_ready, in_data   | opcode (clear/load/query), value
//   out     | out_valid, out_ready, out_data| status, position
//
// The front register and the command queue lie between the input and the engine.
// A clear or a load into a full table goes from idle straight to the result state.
// A load shifts up each stored entry greater than the new value before writing
// it, since the insertion shifter moves one entry per cycle through the single
// memory write port. Each query search step is a memory read, then a compare.
// Reset (rst_n low, synchronous) empties the table and the queue; the table
// memory itself is not cleared, entries above the count are never read.
// Stalls: the front keeps accepting transactions while the queue has room and
// the engine moves on while a result waits in the output register.

module sorted_table_binary_search_unit #(
  parameter int DEPTH      = 256,
  parameter int DATA_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  stbs_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output stbs_pkg::out_item_t out_data
);

  logic           front_valid;
  stbs_pkg::cmd_t front_cmd;
  logic           q_full;
  logic           q_not_empty;
  stbs_pkg::cmd_t q_cmd;
  logic           q_pop;

  // Accept and classify; opcode 3 is dropped here without a result
  stbs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cmd_valid (front_valid),
    .cmd_full  (q_full),
    .cmd       (front_cmd)
  );

  // Decouple the front from the engine
  stbs_cmd_fifo u_cmd_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (front_valid),
    .push_data (front_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_data  (q_cmd)
  );

  // Execute one command at a time and hold its result in the output register
  stbs_engine #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (q_not_empty),
    .cmd       (q_cmd),
    .cmd_pop   (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

@@ hdl/stbs_front.sv @@
// Front stage: accepts input transactions, classifies the opcode, drops opcode 3.
// Depends on stbs_pkg.

module stbs_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  stbs_pkg::in_item_t in_data,
  output logic              cmd_valid,
  input  logic              cmd_full,
  output stbs_pkg::cmd_t    cmd
);

  logic           front_valid_r, front_valid_nxt;
  stbs_pkg::cmd_t front_cmd_r, front_cmd_nxt;
  logic           keep;
  logic           accept;

  assign in_ready  = !front_valid_r || !cmd_full;
  assign accept    = in_valid && in_ready;
  assign cmd_valid = front_valid_r;
  assign cmd       = front_cmd_r;

  always_comb begin
    keep                = 1'b1;
    front_cmd_nxt       = front_cmd_r;
    front_cmd_nxt.value = in_data.value;
    unique case (in_data.opcode)
      stbs_pkg::OP_CLEAR: front_cmd_nxt.kind = stbs_pkg::CMD_CLEAR;
      stbs_pkg::OP_LOAD:  front_cmd_nxt.kind = stbs_pkg::CMD_LOAD;
      stbs_pkg::OP_QUERY: front_cmd_nxt.kind = stbs_pkg::CMD_QUERY;
      default: begin
        keep = 1'b0;
      end
    endcase
    front_valid_nxt = (front_valid_r && cmd_full) || (accept && keep);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_valid_r <= 1'b0;
    end else begin
      front_valid_r <= front_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && keep) begin
      front_cmd_r <= front_cmd_nxt;
    end
  end

endmodule

@@ hdl/stbs_cmd_fifo.sv @@
// Short command queue between the front stage and the search engine.
// Depends on stbs_pkg.

module stbs_cmd_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  stbs_pkg::cmd_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output stbs_pkg::cmd_t pop_data
);

  localparam int D     = stbs_pkg::CMD_Q_DEPTH;
  localparam int PTR_W = (D > 1) ? $clog2(D) : 1;
  localparam int CNT_W = $clog2(D + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(D - 1);
  localparam logic [CNT_W-1:0] FULL_C = CNT_W'(D);

  stbs_pkg::cmd_t   q_r [D];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] fill_r;
  logic             do_push, do_pop;

  assign full      = (fill_r == FULL_C);
  assign not_empty = (fill_r != '0);
  assign pop_data  = q_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill_r <= fill_r + 1'b1;
      end else if (do_pop && !do_push) begin
        fill_r <= fill_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

@@ hdl/stbs_engine.sv @@
// Back end: sorted table memory, insertion shifter, binary search and result register.
// Depends on stbs_pkg.

module stbs_engine #(
  parameter int DEPTH      = 256,
  parameter int DATA_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cmd_valid,
  input  stbs_pkg::cmd_t      cmd,
  output logic                cmd_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output stbs_pkg::out_item_t out_data
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

  logic signed [DATA_WIDTH-1:0] mem [DEPTH];
  logic signed [DATA_WIDTH-1:0] rd_data_r;

  stbs_pkg::eng_state_t         state_r, state_nxt;
  logic [CNT_W-1:0]             count_r, count_nxt;
  logic [CNT_W-1:0]             idx_r, idx_nxt;
  logic [CNT_W-1:0]             lo_r, lo_nxt;
  logic [CNT_W-1:0]             hi_r, hi_nxt;
  logic [IDX_W-1:0]             mid_r, mid_nxt;
  logic signed [DATA_WIDTH-1:0] key_r, key_nxt;
  stbs_pkg::out_item_t          res_r, res_nxt;
  logic                         out_valid_r;
  stbs_pkg::out_item_t          out_data_r;

  logic                         rd_en, wr_en;
  logic [IDX_W-1:0]             rd_addr, wr_addr;
  logic signed [DATA_WIDTH-1:0] wr_data;
  logic                         out_load;
  logic signed [63:0]           value_ext;
  logic [CNT_W:0]               mid_sum;
  logic [IDX_W+7:0]             pos_ext;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Sign-extend, then wrap to the table width
  assign value_ext = {{32{cmd.value[31]}}, cmd.value};
  assign mid_sum   = {1'b0, lo_r} + {1'b0, hi_r} - {{CNT_W{1'b0}}, 1'b1};
  assign pos_ext   = {8'd0, mid_r};

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    mid_nxt   = mid_r;
    key_nxt   = key_r;
    res_nxt   = res_r;
    cmd_pop   = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = '0;
    wr_en     = 1'b0;
    wr_addr   = idx_r[IDX_W-1:0];
    wr_data   = key_r;
    out_load  = 1'b0;

    unique case (state_r)
      stbs_pkg::ENG_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          key_nxt = value_ext[DATA_WIDTH-1:0];
          res_nxt.position = 8'd0;
          unique case (cmd.kind)
            stbs_pkg::CMD_CLEAR: begin
              count_nxt      = '0;
              res_nxt.status = stbs_pkg::ST_CLEARED;
              state_nxt      = stbs_pkg::ENG_RESP;
            end
            stbs_pkg::CMD_LOAD: begin
              idx_nxt = count_r;
              if (count_r == DEPTH_C) begin
                res_nxt.status = stbs_pkg::ST_FULL;
                state_nxt      = stbs_pkg::ENG_RESP;
              end else if (count_r == '0) begin
                state_nxt = stbs_pkg::ENG_INS_WR;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = IDX_W'(count_r - ONE_C);
                state_nxt = stbs_pkg::ENG_INS_CMP;
              end
            end
            stbs_pkg::CMD_QUERY: begin
              lo_nxt    = '0;
              hi_nxt    = count_r;
              state_nxt = stbs_pkg::ENG_SRCH_RD;
            end
            default: begin
              state_nxt = stbs_pkg::ENG_IDLE;
            end
          endcase
        end
      end

      stbs_pkg::ENG_INS_CMP: begin
        if (rd_data_r > key_r) begin
          // Move the larger entry up one slot, look at the next one down
          wr_en   = 1'b1;
          wr_data = rd_data_r;
          idx_nxt = idx_r - ONE_C;
          if (idx_r == ONE_C) begin
            state_nxt = stbs_pkg::ENG_INS_WR;
          end else begin
            rd_en   = 1'b1;
            rd_addr = IDX_W'(idx_r - CNT_W'(2));
          end
        end else begin
          wr_en          = 1'b1;
          count_nxt      = count_r + ONE_C;
          res_nxt.status = stbs_pkg::ST_LOADED;
          state_nxt      = stbs_pkg::ENG_RESP;
        end
      end

      stbs_pkg::ENG_INS_WR: begin
        wr_en          = 1'b1;
        count_nxt      = count_r + ONE_C;
        res_nxt.status = stbs_pkg::ST_LOADED;
        state_nxt      = stbs_pkg::ENG_RESP;
      end

      stbs_pkg::ENG_SRCH_RD: begin
        if (lo_r < hi_r) begin
          mid_nxt   = mid_sum[IDX_W:1];
          rd_en     = 1'b1;
          rd_addr   = mid_sum[IDX_W:1];
          state_nxt = stbs_pkg::ENG_SRCH_CMP;
        end else begin
          res_nxt.status = stbs_pkg::ST_NOTFOUND;
          state_nxt      = stbs_pkg::ENG_RESP;
        end
      end

      stbs_pkg::ENG_SRCH_CMP: begin
        if (key_r == rd_data_r) begin
          res_nxt.status   = stbs_pkg::ST_FOUND;
          res_nxt.position = pos_ext[7:0];
          state_nxt        = stbs_pkg::ENG_RESP;
        end else if (key_r < rd_data_r) begin
          hi_nxt    = CNT_W'(mid_r);
          state_nxt = stbs_pkg::ENG_SRCH_RD;
        end else begin
          lo_nxt    = CNT_W'(mid_r) + ONE_C;
          state_nxt = stbs_pkg::ENG_SRCH_RD;
        end
      end

      stbs_pkg::ENG_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = stbs_pkg::ENG_IDLE;
        end
      end

      default: begin
        state_nxt = stbs_pkg::ENG_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= stbs_pkg::ENG_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    lo_r  <= lo_nxt;
    hi_r  <= hi_nxt;
    mid_r <= mid_nxt;
    key_r <= key_nxt;
    res_r <= res_nxt;
    if (out_load) begin
      out_data_r <= res_r;
    end
  end

  // Table memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

@@ tb/sorted_table_binary_search_unit_test.sv @@
// Self-checking testbench for sorted_table_binary_search_unit.
// Depends on stbs_pkg and the unit itself. It predicts every result with its
// own sorted table and its own binary search, and drives both channels with random idling.

module sorted_table_binary_search_unit_test;

  localparam int TABLE_DEPTH = 256;
  localparam logic [1:0] OP_UNUSED = 2'd3;   // ignored by the unit, no result
  localparam int TOTAL_ITEMS = 1850;
  localparam int IDLE_LIMIT = 5000;          // cycles with no transaction at all
  localparam int HOLD_CYCLES = 400;          // long receiver hold-off
  localparam int DRAIN_CYCLES = 300;         // covers the slowest load shift

  // Predicts results from a private copy of the sorted table and checks the
  // results in order against the predictions.
  class search_scoreboard;
    logic signed [31:0] sorted_vals[TABLE_DEPTH];
    int entry_count;
    stbs_pkg::out_item_t expected_q[$];
    int errors;

    function new();
      entry_count = 0;
      errors = 0;
    endfunction

    function void note_input(stbs_pkg::in_item_t item);
      stbs_pkg::out_item_t res;
      int i;
      int lo;
      int hi;
      int mid;
      res.status = stbs_pkg::ST_NOTFOUND;
      res.position = '0;
      case (item.opcode)
        stbs_pkg::OP_CLEAR: begin
          entry_count = 0;
          res.status = stbs_pkg::ST_CLEARED;
        end
        stbs_pkg::OP_LOAD: begin
          if (entry_count >= TABLE_DEPTH) begin
            res.status = stbs_pkg::ST_FULL;
          end else begin
            // Insert after any equal entries.
            i = entry_count;
            while (i > 0 && sorted_vals[i - 1] > item.value) begin
              sorted_vals[i] = sorted_vals[i - 1];
              i--;
            end
            sorted_vals[i] = item.value;
            entry_count++;
            res.status = stbs_pkg::ST_LOADED;
          end
        end
        stbs_pkg::OP_QUERY: begin
          // Classic search: stop at the first equal midpoint.
          lo = 0;
          hi = entry_count - 1;
          while (lo <= hi) begin
            mid = (lo + hi) / 2;
            if (item.value == sorted_vals[mid]) begin
              res.status = stbs_pkg::ST_FOUND;
              res.position = mid[7:0];
              break;
            end else if (item.value < sorted_vals[mid]) begin
              hi = mid - 1;
            end else begin
              lo = mid + 1;
            end
          end
        end
        default: return;  // unused opcode: no result, no state change
      endcase
      expected_q.push_back(res);
    endfunction

    function void check_result(stbs_pkg::out_item_t got);
      stbs_pkg::out_item_t want;
      if (expected_q.size() == 0) begin
        $error("unexpected result: status %0d position %0d", got.status, got.position);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
      if (got.position !== want.position) begin
        $error("position: expected %0d, got %0d", want.position, got.position);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  stbs_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  stbs_pkg::out_item_t out_data;

  search_scoreboard sb = new();

  int items_sent = 0;
  bit send_burst = 1'b0;    // sender offers back to back
  bit recv_burst = 1'b0;    // receiver never stalls
  bit hold_request = 1'b0;  // receiver holds off for a long stretch
  int idle_cycles = 0;

  sorted_table_binary_search_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: end the run when no transaction moves for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("** sorted_table_binary_search_unit: FAILED **");
        $finish;
      end
    end
  end

  // Offer one transaction and hold it until accepted.
  task automatic send_item(input logic [1:0] op, input logic [31:0] val);
    stbs_pkg::in_item_t item;
    int gap;
    item.opcode = op;
    item.value = val;
    gap = send_burst ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (!in_ready);
    sb.note_input(item);
    if (op != OP_UNUSED) items_sent++;
  endtask

  // Result side: stall at random, take one transaction, check it.
  initial begin
    int stall;
    int taken;
    taken = 0;
    @(posedge rst_n);
    forever begin
      if (taken % 64 == 0) recv_burst = ($urandom_range(0, 3) == 0);
      if (hold_request) begin
        stall = HOLD_CYCLES;
        hold_request = 1'b0;
      end else begin
        stall = recv_burst ? 0 : $urandom_range(0, 13);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      sb.check_result(out_data);
      taken++;
    end
  end

  function automatic logic signed [31:0] pick_value(int mode);
    case (mode)
      0: return 32'(int'($urandom_range(0, 16)) - 8);   // dense, many duplicates
      1: begin
        case ($urandom_range(0, 5))
          0: return 32'sh8000_0000;
          1: return 32'sh7FFF_FFFF;
          2: return 32'sh8000_0001;
          3: return 32'sh7FFF_FFFE;
          4: return 32'sh0000_0000;
          default: return -32'sd1;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  // One random sequence: mostly clear, loads, then queries on what was loaded;
  // sometimes a fill past capacity; sometimes plain noise.
  task automatic run_sequence(input bit force_fill);
    logic signed [31:0] loaded[$];
    logic signed [31:0] base;
    logic signed [31:0] key;
    int kind;
    int mode;
    int order;
    int n;
    int nq;
    bit fill;
    kind = $urandom_range(0, 99);
    send_burst = ($urandom_range(0, 3) == 0);
    if (kind < 12 && !force_fill) begin
      repeat ($urandom_range(1, 8)) send_item(2'($urandom_range(0, 3)), $urandom);
      return;
    end
    fill = force_fill || ($urandom_range(0, 39) == 0);
    if (fill || $urandom_range(0, 4) != 0) send_item(stbs_pkg::OP_CLEAR, $urandom);
    mode = $urandom_range(0, 2);
    order = $urandom_range(0, 3);
    base = $urandom;
    n = fill ? TABLE_DEPTH + $urandom_range(1, 4) : $urandom_range(1, 12);
    for (int i = 0; i < n; i++) begin
      if (!fill || order == 0) key = pick_value(mode);
      else if (order == 1) key = base + i;
      else if (order == 2) key = base - i;
      else key = base;
      loaded.push_back(key);
      send_item(stbs_pkg::OP_LOAD, key);
    end
    nq = fill ? 24 : $urandom_range(1, 2 * n + 2);
    for (int i = 0; i < nq; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: key = loaded[$urandom_range(0, loaded.size() - 1)];
        6, 7: key = loaded[$urandom_range(0, loaded.size() - 1)]
                    + ($urandom_range(0, 1) ? 32'sd1 : -32'sd1);
        default: key = pick_value(mode);
      endcase
      send_item(stbs_pkg::OP_QUERY, key);
      // Break the sequence now and then.
      if ($urandom_range(0, 29) == 0) send_item(OP_UNUSED, $urandom);
      if ($urandom_range(0, 59) == 0) send_item(stbs_pkg::OP_CLEAR, $urandom);
    end
  endtask

  initial begin
    bit held_twice;
    held_twice = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty table, unused opcode, extremes, duplicates, clear.
    send_item(stbs_pkg::OP_QUERY, 32'sd5);
    send_item(OP_UNUSED, 32'sd7);
    send_item(stbs_pkg::OP_CLEAR, 32'sd0);
    send_item(stbs_pkg::OP_LOAD, 32'sh7FFF_FFFF);
    send_item(stbs_pkg::OP_LOAD, 32'sh8000_0000);
    send_item(stbs_pkg::OP_LOAD, 32'sd0);
    send_item(stbs_pkg::OP_LOAD, -32'sd1);
    send_item(stbs_pkg::OP_LOAD, 32'sd5);
    send_item(stbs_pkg::OP_LOAD, 32'sd5);
    send_item(stbs_pkg::OP_LOAD, 32'sd5);
    send_item(stbs_pkg::OP_QUERY, 32'sd5);
    send_item(stbs_pkg::OP_QUERY, 32'sh7FFF_FFFF);
    send_item(stbs_pkg::OP_QUERY, 32'sh8000_0000);
    send_item(stbs_pkg::OP_QUERY, -32'sd1);
    send_item(stbs_pkg::OP_QUERY, 32'sd4);
    send_item(stbs_pkg::OP_QUERY, 32'sd6);
    send_item(OP_UNUSED, 32'hFFFF_FFFF);
    send_item(stbs_pkg::OP_QUERY, 32'sh8000_0001);
    send_item(stbs_pkg::OP_CLEAR, 32'hFFFF_FFFF);
    send_item(stbs_pkg::OP_QUERY, 32'sd5);
    send_item(stbs_pkg::OP_LOAD, 32'sd1);
    send_item(stbs_pkg::OP_QUERY, 32'sd1);

    // Random: first a fill past capacity under a long receiver hold-off.
    hold_request = 1'b1;
    run_sequence(1'b1);
    while (items_sent < TOTAL_ITEMS) begin
      if (!held_twice && items_sent > TOTAL_ITEMS / 2) begin
        hold_request = 1'b1;
        held_twice = 1'b1;
      end
      run_sequence(1'b0);
    end
    in_valid <= 1'b0;

    // Drain, then give a stray result time to show up.
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("** sorted_table_binary_search_unit: PASSED **");
    end else begin
      $display("** sorted_table_binary_search_unit: FAILED **");
    end
    $finish;
  end

endmodule
